// File: sv/priority_round_robin_ready_queue_macros.svh
// Assertion macros shared by the ready queue RTL.
`ifndef PRIORITY_ROUND_ROBIN_READY_QUEUE_MACROS_SVH
`define PRIORITY_ROUND_ROBIN_READY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRRQ_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRRQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/prrq_pkg.sv
// Shared types and constants for the priority round-robin ready queue.
package prrq_pkg;

    localparam int PID_W    = 22;
    localparam int PRIO_W   = 4;
    localparam int ENTRY_W  = PID_W + PRIO_W;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;

    localparam logic CMD_ENQUEUE  = 1'b0;
    localparam logic CMD_DISPATCH = 1'b1;

    typedef enum logic [1:0] {
        ST_ENQUEUED   = 2'd0,
        ST_FULL       = 2'd1,
        ST_DISPATCHED = 2'd2,
        ST_EMPTY      = 2'd3
    } status_t;

    // One command as held in the input register.
    typedef struct packed {
        logic              cmd;
        logic [PID_W-1:0]  pid;
        logic [PRIO_W-1:0] prio;
    } req_t;

endpackage

// File: sv/prrq_ram.sv
// Generic single-port RAM with registered read.
module prrq_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 176,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/prrq_ctrl.sv
// Per-level head/count state, level selection and entry RAM addressing.
module prrq_ctrl #(
    parameter int LEVELS = 11,
    parameter int QUEUE_DEPTH = 16,
    localparam int ADDR_W = $clog2(LEVELS * QUEUE_DEPTH)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    go,
    input  logic                    mode,
    input  prrq_pkg::req_t          req,
    output prrq_pkg::status_t       status,
    output logic                    ram_en,
    output logic                    ram_we,
    output logic [ADDR_W-1:0]       ram_addr,
    output logic [prrq_pkg::ENTRY_W-1:0] ram_wdata
);

    localparam int LVL_W  = $clog2(LEVELS);
    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam logic [prrq_pkg::PRIO_W-1:0] PRIO_MAX = prrq_pkg::PRIO_W'(LEVELS - 1);

    logic [CNT_W-1:0]  count_reg [LEVELS];
    logic [CNT_W-1:0]  count_next [LEVELS];
    logic [SLOT_W-1:0] head_reg [LEVELS];
    logic [SLOT_W-1:0] head_next [LEVELS];

    logic [prrq_pkg::PRIO_W-1:0] sat_prio;
    logic [LVL_W-1:0]  enq_lvl;
    logic [LVL_W-1:0]  disp_lvl;
    logic              disp_found;
    logic [LVL_W-1:0]  sel_lvl;
    logic [CNT_W-1:0]  sel_count;
    logic [SLOT_W-1:0] sel_head;
    logic [SLOT_W-1:0] head_inc;
    logic [SUM_W-1:0]  tail_sum;
    logic [SUM_W-1:0]  tail_wrap;
    logic [SLOT_W-1:0] slot;
    logic              is_disp;
    logic              full;

    always_comb begin
        is_disp  = (req.cmd == prrq_pkg::CMD_DISPATCH);
        sat_prio = (req.prio > PRIO_MAX) ? PRIO_MAX : req.prio;
        enq_lvl  = mode ? sat_prio[LVL_W-1:0] : '0;

        // Highest non-empty level above 0 wins in priority mode.
        disp_lvl   = '0;
        disp_found = 1'b0;
        for (int i = 1; i < LEVELS; i++) begin
            if (count_reg[i] != '0) begin
                disp_lvl   = LVL_W'(i);
                disp_found = 1'b1;
            end
        end
        if (!mode) begin
            disp_lvl   = '0;
            disp_found = (count_reg[0] != '0);
        end

        sel_lvl   = is_disp ? disp_lvl : enq_lvl;
        sel_count = count_reg[sel_lvl];
        sel_head  = head_reg[sel_lvl];
        full      = (sel_count == CNT_W'(QUEUE_DEPTH));

        tail_sum  = SUM_W'(sel_head) + SUM_W'(sel_count);
        tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? tail_sum - SUM_W'(QUEUE_DEPTH)
                                                      : tail_sum;
        slot      = is_disp ? sel_head : tail_wrap[SLOT_W-1:0];
        head_inc  = (sel_head == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : sel_head + 1'b1;
    end

    always_comb begin
        if (is_disp) begin
            status = disp_found ? prrq_pkg::ST_DISPATCHED : prrq_pkg::ST_EMPTY;
        end else begin
            status = full ? prrq_pkg::ST_FULL : prrq_pkg::ST_ENQUEUED;
        end
        ram_we    = go && !is_disp && !full;
        ram_en    = ram_we || (go && is_disp && disp_found);
        ram_addr  = ADDR_W'(sel_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
        ram_wdata = {sat_prio, req.pid};
    end

    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            count_next[i] = count_reg[i];
            head_next[i]  = head_reg[i];
        end
        if (go) begin
            if (is_disp && disp_found) begin
                count_next[sel_lvl] = sel_count - 1'b1;
                head_next[sel_lvl]  = head_inc;
            end else if (!is_disp && !full) begin
                count_next[sel_lvl] = sel_count + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
            end
        end else begin
            for (int i = 0; i < LEVELS; i++) begin
                count_reg[i] <= count_next[i];
                head_reg[i]  <= head_next[i];
            end
        end
    end

endmodule

// File: sv/priority_round_robin_ready_queue.sv
// Multilevel ready queue: input register, stage B (entry RAM read), output register.
// Throughput is one request per cycle unless m_tready stalls; level state updates in
// the cycle a request leaves the input register and starts its entry RAM access.
// aresetn (synchronous, active low) empties every level, clears the pipeline and
// sets scheduling_mode to round robin; entry RAM contents are not cleared.
`include "priority_round_robin_ready_queue_macros.svh"
module priority_round_robin_ready_queue #(
    parameter int LEVELS = 11,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config: scheduling_mode
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [prrq_pkg::S_DATA_W-1:0] s_tdata,  // pid[21:0], priority_req[25:22]
    input  logic                          s_tuser,  // cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [prrq_pkg::M_DATA_W-1:0] m_tdata,  // out_pid[21:0], out_priority[25:22]
    output logic [1:0]                    m_tuser   // status
);

    localparam int ADDR_W = $clog2(LEVELS * QUEUE_DEPTH);
    localparam int PID_W  = prrq_pkg::PID_W;
    localparam int PRIO_W = prrq_pkg::PRIO_W;

    logic                 mode_reg;
    logic                 valid_a_reg;
    prrq_pkg::req_t       req_a_reg;
    logic                 valid_b_reg;
    prrq_pkg::status_t    status_b_reg;
    logic                 valid_c_reg;
    logic [1:0]           status_c_reg;
    logic [PID_W-1:0]     pid_c_reg;
    logic [PRIO_W-1:0]    prio_c_reg;

    logic                 c_free;
    logic                 b_adv;
    logic                 b_free;
    logic                 a_adv;
    prrq_pkg::status_t    status_a;
    logic                 ram_en;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [prrq_pkg::ENTRY_W-1:0] ram_wdata;
    logic [prrq_pkg::ENTRY_W-1:0] ram_rdata;
    logic [PID_W-1:0]     pid_b;
    logic [PRIO_W-1:0]    prio_b;

    assign cfg_ready = 1'b1;
    assign c_free    = !valid_c_reg || m_tready;
    assign b_adv     = valid_b_reg && c_free;
    assign b_free    = !valid_b_reg || c_free;
    assign a_adv     = valid_a_reg && b_free;
    assign s_tready  = !valid_a_reg || b_free;

    prrq_ctrl #(
        .LEVELS      (LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .go        (a_adv),
        .mode      (mode_reg),
        .req       (req_a_reg),
        .status    (status_a),
        .ram_en    (ram_en),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata)
    );

    prrq_ram #(
        .WIDTH (prrq_pkg::ENTRY_W),
        .DEPTH (LEVELS * QUEUE_DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Only a dispatch carries the entry; everything else reports zeros.
    always_comb begin
        if (status_b_reg == prrq_pkg::ST_DISPATCHED) begin
            pid_b  = ram_rdata[PID_W-1:0];
            prio_b = ram_rdata[prrq_pkg::ENTRY_W-1:PID_W];
        end else begin
            pid_b  = '0;
            prio_b = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= 1'b0;
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
            if (s_tready) begin
                valid_a_reg <= s_tvalid;
            end
            if (b_free) begin
                valid_b_reg <= a_adv;
            end
            if (c_free) begin
                valid_c_reg <= b_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            req_a_reg.cmd  <= s_tuser;
            req_a_reg.pid  <= s_tdata[PID_W-1:0];
            req_a_reg.prio <= s_tdata[PID_W+PRIO_W-1:PID_W];
        end
        if (a_adv) begin
            status_b_reg <= status_a;
        end
        if (b_adv) begin
            status_c_reg <= status_b_reg;
            pid_c_reg    <= pid_b;
            prio_c_reg   <= prio_b;
        end
    end

    assign m_tvalid = valid_c_reg;
    assign m_tuser  = status_c_reg;
    assign m_tdata  = {{(prrq_pkg::M_DATA_W - PID_W - PRIO_W){1'b0}}, prio_c_reg, pid_c_reg};

    `PRRQ_ASSERT_NOW(a_zero_unless_dispatch, aclk, aresetn,
        m_tvalid && (m_tuser != prrq_pkg::ST_DISPATCHED), m_tdata == '0,
        "non-dispatch result carries a nonzero payload")
    `PRRQ_ASSERT_NOW(a_stall_only_when_full, aclk, aresetn,
        !s_tready, m_tvalid && !m_tready && valid_b_reg && valid_a_reg,
        "input stalled while the pipeline has room")
    `PRRQ_ASSERT_NEXT(a_stage_b_loads, aclk, aresetn,
        a_adv, valid_b_reg,
        "request left the input register but stage B is empty")
    `PRRQ_ASSERT_NEXT(a_result_loads, aclk, aresetn,
        b_adv, m_tvalid,
        "stage B advanced but no result is presented")

endmodule
